// ----- rtl/tpdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Telemetry packet deframer package
// Shared word types, header positions, status codes and size limits.
// ----------------------------------------------------------------------------
package tpdc_pkg;

  // Largest payload length accepted from the header
  localparam logic [7:0] MAX_PAYLOAD = 8'd64;

  // Header byte positions; HDR_DONE means the payload is being received
  localparam logic [3:0] HDR_ID     = 4'd0;
  localparam logic [3:0] HDR_LEN    = 4'd1;
  localparam logic [3:0] HDR_TIME0  = 4'd2;
  localparam logic [3:0] HDR_TIME3  = 4'd5;
  localparam logic [3:0] HDR_CHK_LO = 4'd6;
  localparam logic [3:0] HDR_CHK_HI = 4'd7;
  localparam logic [3:0] HDR_DONE   = 4'd8;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  // Input word: one datagram byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       datagram_start;
  } in_word_t;

  // Result word: payload byte and/or end-of-packet report
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_offset;
    logic        packet_end;
    logic [7:0]  packet_id;
    logic [7:0]  packet_length;
    logic [31:0] packet_time;
    status_t     status;
  } out_word_t;

endpackage

// ----- rtl/tpdc_in_if.sv -----
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel carrying one received datagram byte per word.
// ----------------------------------------------------------------------------
interface tpdc_in_if;
  logic              valid;
  logic              ready;
  tpdc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tpdc_out_if.sv -----
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying a payload byte, a packet report or both per word.
// ----------------------------------------------------------------------------
interface tpdc_out_if;
  logic               valid;
  logic               ready;
  tpdc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/telemetry_packet_deframe_check.sv -----
// ----------------------------------------------------------------------------
// Telemetry packet deframer and checksum check
// Parses id, length, timestamp and checksum header bytes, passes payload
// bytes on with their offset and reports the packet with a Fletcher-16
// (mod 256) check status on its final byte, or as too long on its length byte.
// ----------------------------------------------------------------------------
//   channel | direction | word
//   rx      | in        | rx_byte, datagram_start
//   res     | out       | payload byte/offset, packet end report, status
//
// One byte is taken every cycle while rx.ready is high; the header parser and
// the two 8-bit running sums are combinational between the parser state and
// the result register. Each result is registered as its byte is taken.
// A skid register behind the result register lets one more byte in while res
// stalls; rx.ready drops only when both are full.
// Reset (rst, synchronous) idles the parser until the next datagram start.
// ----------------------------------------------------------------------------
module telemetry_packet_deframe_check (
  input  logic            clk,
  input  logic            rst,
  tpdc_in_if.sink         rx,
  tpdc_out_if.source      res
);

  // Parser state
  logic [3:0]  hdr_pos;
  logic [7:0]  pay_pos;
  logic        active;
  logic [7:0]  held_id;
  logic [7:0]  held_length;
  logic [31:0] held_time;
  logic [15:0] received_check;
  logic [7:0]  sum_low;
  logic [7:0]  sum_high;

  logic [3:0]  hdr_pos_next;
  logic [7:0]  pay_pos_next;
  logic        active_next;
  logic [7:0]  held_id_next;
  logic [7:0]  held_length_next;
  logic [31:0] held_time_next;
  logic [15:0] received_check_next;
  logic [7:0]  sum_low_next;
  logic [7:0]  sum_high_next;

  // Result register and skid register
  logic                out_valid;
  tpdc_pkg::out_word_t out_word;
  logic                skid_valid;
  tpdc_pkg::out_word_t skid_word;

  logic                accept;
  logic                push;
  logic                out_take;
  tpdc_pkg::out_word_t new_word;

  logic [7:0]  b;
  logic [7:0]  acc_low;
  logic [7:0]  acc_high;
  logic [1:0]  time_idx;
  logic [7:0]  pay_pos_inc;
  logic        sums_match;

  assign accept   = rx.valid && rx.ready;
  assign out_take = out_valid && res.ready;
  assign rx.ready = !skid_valid;
  assign b        = rx.data.rx_byte;
  assign time_idx = 2'(hdr_pos - tpdc_pkg::HDR_TIME0);

  // Parse one byte and update the running sums
  always_comb begin
    hdr_pos_next        = hdr_pos;
    pay_pos_next        = pay_pos;
    active_next         = active;
    held_id_next        = held_id;
    held_length_next    = held_length;
    held_time_next      = held_time;
    received_check_next = received_check;
    sum_low_next        = sum_low;
    sum_high_next       = sum_high;
    new_word            = '0;
    push                = 1'b0;

    // Clear packet state on a datagram start
    if (rx.data.datagram_start) begin
      hdr_pos_next        = tpdc_pkg::HDR_ID;
      pay_pos_next        = '0;
      active_next         = 1'b1;
      held_id_next        = '0;
      held_length_next    = '0;
      held_time_next      = '0;
      received_check_next = '0;
      sum_low_next        = '0;
      sum_high_next       = '0;
    end

    acc_low     = sum_low_next + b;
    acc_high    = sum_high_next + acc_low;
    pay_pos_inc = pay_pos_next + 8'd1;
    sums_match  = ({sum_high_next, sum_low_next} == {b, received_check_next[7:0]});

    if (active_next) begin
      if (hdr_pos_next != tpdc_pkg::HDR_DONE) begin
        hdr_pos_next = hdr_pos_next + 4'd1;
        if (hdr_pos_next == tpdc_pkg::HDR_LEN) begin
          held_id_next  = b;
          sum_low_next  = acc_low;
          sum_high_next = acc_high;
        end else if (hdr_pos_next == tpdc_pkg::HDR_TIME0) begin
          held_length_next = b;
          sum_low_next     = acc_low;
          sum_high_next    = acc_high;
          // Report an oversized length and drop the rest of the datagram
          if (b > tpdc_pkg::MAX_PAYLOAD) begin
            new_word.packet_end    = 1'b1;
            new_word.packet_id     = held_id_next;
            new_word.packet_length = b;
            new_word.status        = tpdc_pkg::STATUS_TOO_LONG;
            push                   = 1'b1;
            active_next            = 1'b0;
          end
        end else if (hdr_pos_next <= tpdc_pkg::HDR_TIME3 + 4'd1) begin
          held_time_next[time_idx*8 +: 8] = held_time_next[time_idx*8 +: 8] | b;
          sum_low_next  = acc_low;
          sum_high_next = acc_high;
        end else if (hdr_pos_next == tpdc_pkg::HDR_CHK_LO + 4'd1) begin
          received_check_next[7:0] = b;
        end else begin
          received_check_next[15:8] = b;
          // Empty payload: report on the last checksum byte
          if (held_length_next == 8'd0) begin
            new_word.packet_end    = 1'b1;
            new_word.packet_id     = held_id_next;
            new_word.packet_length = held_length_next;
            new_word.packet_time   = held_time_next;
            new_word.status        = sums_match ? tpdc_pkg::STATUS_OK
                                                : tpdc_pkg::STATUS_MISMATCH;
            push                   = 1'b1;
            active_next            = 1'b0;
          end
        end
      end else begin
        // Pass a payload byte on and close the packet on its last byte
        sum_low_next            = acc_low;
        sum_high_next           = acc_high;
        new_word.payload_valid  = 1'b1;
        new_word.payload_byte   = b;
        new_word.payload_offset = pay_pos_next[5:0];
        pay_pos_next            = pay_pos_inc;
        push                    = 1'b1;
        if (pay_pos_inc >= held_length_next) begin
          new_word.packet_end    = 1'b1;
          new_word.packet_id     = held_id_next;
          new_word.packet_length = held_length_next;
          new_word.packet_time   = held_time_next;
          new_word.status        = ({acc_high, acc_low} == received_check_next)
                                   ? tpdc_pkg::STATUS_OK : tpdc_pkg::STATUS_MISMATCH;
          active_next            = 1'b0;
        end
      end
    end
  end

  // Hold parser state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos        <= '0;
      pay_pos        <= '0;
      active         <= 1'b0;
      held_id        <= '0;
      held_length    <= '0;
      held_time      <= '0;
      received_check <= '0;
      sum_low        <= '0;
      sum_high       <= '0;
    end else if (accept) begin
      hdr_pos        <= hdr_pos_next;
      pay_pos        <= pay_pos_next;
      active         <= active_next;
      held_id        <= held_id_next;
      held_length    <= held_length_next;
      held_time      <= held_time_next;
      received_check <= received_check_next;
      sum_low        <= sum_low_next;
      sum_high       <= sum_high_next;
    end
  end

  // Result register with skid: drain skid first, keep order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && push;
        out_word  <= new_word;
      end
    end else if (accept && push) begin
      skid_valid <= 1'b1;
      skid_word  <= new_word;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_word;

endmodule

// ----- rtl/tpdc_checker.sv -----
// ----------------------------------------------------------------------------
// Telemetry packet deframer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tpdc_props (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input tpdc_pkg::out_word_t res_data
);

  // Hold a stalled result word unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result word changed while stalled");

  // Every result carries a payload byte or an end report
  a_res_content: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.payload_valid || res_data.packet_end)
    else $error("empty result word");

  // Report fields stay zero outside the end of a packet
  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.packet_end |->
      res_data.packet_id == 8'd0 && res_data.packet_length == 8'd0 &&
      res_data.packet_time == 32'd0 && res_data.status == tpdc_pkg::STATUS_OK)
    else $error("report fields set without packet end");

  // Oversized length ends the packet with no payload and no timestamp
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == tpdc_pkg::STATUS_TOO_LONG |->
      res_data.packet_end && !res_data.payload_valid &&
      res_data.packet_time == 32'd0 && res_data.packet_length > tpdc_pkg::MAX_PAYLOAD)
    else $error("bad length-too-large report");

endmodule

bind telemetry_packet_deframe_check tpdc_props u_tpdc_props (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
